// ===== sv/oif_pkg.sv =====
package oif_pkg;

  // grid limits
  localparam int MaxWidth  = 1024;
  localparam int MaxHeight = 1024;
  localparam int MaxRadius = 7;

  localparam int ColW = $clog2(MaxWidth);
  localparam int RowW = $clog2(MaxHeight);
  localparam int DimW = ColW + 1;
  localparam int RadW = $clog2(MaxRadius + 1);
  localparam int LinW = 21;

  // raw ring holds enough rows for the widest look-ahead at width one
  localparam int RawRowsLog = 5;
  localparam int InfRowsLog = 2;

  // cell classes
  localparam logic [1:0] ClsFree = 2'd0;
  localparam logic [1:0] ClsOcc  = 2'd1;
  localparam logic [1:0] ClsUnk  = 2'd2;

  // register indexes
  localparam logic [1:0] RegWidth  = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;
  localparam logic [1:0] RegRadius = 2'd2;
  localparam logic [1:0] RegThresh = 2'd3;

  localparam logic [10:0] ResetWidth  = 11'd1024;
  localparam logic [10:0] ResetHeight = 11'd1024;
  localparam logic [2:0]  ResetRadius = 3'd3;
  localparam logic [6:0]  ResetThresh = 7'd65;

  typedef enum logic [6:0] {
    StIdle   = 7'b0000001,
    StScan   = 7'b0000010,
    StDrain  = 7'b0000100,
    StInfWr  = 7'b0001000,
    StFScan  = 7'b0010000,
    StFDrain = 7'b0100000,
    StEmit   = 7'b1000000
  } state_e;

  // raw value to class
  function automatic logic [1:0] classify(input logic signed [7:0] v, input logic [6:0] thr);
    logic [1:0] c;
    if (!v[7] && (v[6:0] < thr)) c = ClsFree;
    else if (v == -8'sd1)        c = ClsUnk;
    else                         c = ClsOcc;
    return c;
  endfunction

  // window lower edge, clipped at zero
  function automatic logic [ColW-1:0] lo_b(input logic [ColW-1:0] p, input logic [RadW-1:0] r);
    logic [ColW-1:0] re;
    re = {{(ColW-RadW){1'b0}}, r};
    return (p >= re) ? p - re : '0;
  endfunction

  // window upper edge, clipped at lim-1
  function automatic logic [ColW-1:0] hi_b(input logic [ColW-1:0] p, input logic [RadW-1:0] r,
                                           input logic [DimW-1:0] lim);
    logic [DimW-1:0] s;
    logic [DimW-1:0] m;
    s = {1'b0, p} + {{(DimW-RadW){1'b0}}, r};
    m = lim - 1'b1;
    return (s > m) ? m[ColW-1:0] : s[ColW-1:0];
  endfunction

endpackage

// ===== sv/occupancy_inflate_frontier_unit.sv =====
// Latency: a cell's result leaves with the transaction (R+1)*W+R+1 places later; that
//   accept scans the clipped (2R+1)x(2R+1) raw window, drains and writes the inflated
//   cell (not once every grid row is inflated), then scans the clipped 3x3 inflated
//   window, drains and emits if a result is due; each ring's single read port holds
//   off new transactions until then, and a result held by the receiver stalls the input.
// Reset: counters and config go to defaults at once; both memories need no clearing.
module occupancy_inflate_frontier_unit (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     cmd_i,
  input  logic signed [7:0]        cell_value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [oif_pkg::ColW-1:0] cell_x_o,
  output logic [oif_pkg::RowW-1:0] cell_y_o,
  output logic [1:0]               inflated_class_o,
  output logic                     is_frontier_o,
  output logic                     last_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [1:0]               cfg_index_i,
  input  logic [10:0]              cfg_data_i
);
  import oif_pkg::*;

  // config registers
  logic [10:0] width_q, height_q;
  logic [2:0]  radius_q;
  logic [6:0]  thresh_q;

  // stream counters
  logic [ColW-1:0] in_col_q, ic_q, oc_q;
  logic [DimW-1:0] in_row_q, ir_q;
  logic [RowW-1:0] or_q;
  logic [LinW-1:0] lin_q;
  logic            inf_act_q, out_act_q;

  // per-item work registers
  state_e          state_q;
  logic [ColW-1:0] a_q, x_q, sx_q;
  logic [RowW-1:0] b_q, y_q, sy_q;
  logic            last_q, out_go_q;
  logic            occ_q, unk_q, rv_q, iv_q, ctr_q;
  logic [1:0]      ctrcls_q, fcls_q;
  logic [1:0]      raw_rd_q, inf_rd_q;

  logic [1:0] raw_mem [2**(RawRowsLog+ColW)];
  logic [1:0] inf_mem [2**(InfRowsLog+ColW)];

  // output register
  logic            out_valid_q, front_q, olast_q;
  logic [ColW-1:0] ox_q;
  logic [RowW-1:0] oy_q;
  logic [1:0]      ocls_q;

  // effective dimensions and delays
  logic [DimW-1:0] w_eff, h_eff;
  logic [13:0]     rw_r;
  logic [14:0]     delay;
  assign w_eff = (width_q == '0) ? DimW'(1) :
                 (width_q > DimW'(MaxWidth)) ? DimW'(MaxWidth) : width_q;
  assign h_eff = (height_q == '0) ? DimW'(1) :
                 (height_q > DimW'(MaxHeight)) ? DimW'(MaxHeight) : height_q;
  assign rw_r  = 14'(radius_q) * 14'(w_eff) + 14'(radius_q);
  assign delay = {1'b0, rw_r} + {4'd0, w_eff} + 15'd1;

  // handshakes
  logic in_fire, cfg_fire;
  assign in_ready_o  = (state_q == StIdle);
  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  // decisions for the item being accepted
  logic in_grid, inf_go, inf_do, out_go, is_last;
  assign in_grid = (in_row_q < h_eff) && ({1'b0, in_col_q} < w_eff);
  assign inf_go  = inf_act_q || (lin_q == LinW'(rw_r));
  assign inf_do  = inf_go && (ir_q < h_eff);
  assign out_go  = out_act_q || (lin_q == LinW'(delay));
  assign is_last = out_go && ({1'b0, oc_q} == w_eff - 1'b1) && ({1'b0, or_q} == h_eff - 1'b1);

  // current scan window
  logic [ColW-1:0] xlo, xhi, cx;
  logic [RowW-1:0] ylo, yhi, cy;
  logic            scanning, at_ctr;
  always_comb begin
    if (state_q == StFScan) begin
      xlo = lo_b(x_q, RadW'(1));
      xhi = hi_b(x_q, RadW'(1), w_eff);
      ylo = lo_b(y_q, RadW'(1));
      yhi = hi_b(y_q, RadW'(1), h_eff);
      cx  = x_q;
      cy  = y_q;
    end else begin
      xlo = lo_b(a_q, radius_q);
      xhi = hi_b(a_q, radius_q, w_eff);
      ylo = lo_b(b_q, radius_q);
      yhi = hi_b(b_q, radius_q, h_eff);
      cx  = a_q;
      cy  = b_q;
    end
  end
  assign scanning = (state_q == StScan) || (state_q == StFScan);
  assign at_ctr   = (sx_q == cx) && (sy_q == cy);

  // config and stream counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= ResetWidth;
      height_q  <= ResetHeight;
      radius_q  <= ResetRadius;
      thresh_q  <= ResetThresh;
      in_col_q  <= '0;
      in_row_q  <= '0;
      lin_q     <= '0;
      ic_q      <= '0;
      ir_q      <= '0;
      oc_q      <= '0;
      or_q      <= '0;
      inf_act_q <= 1'b0;
      out_act_q <= 1'b0;
    end else if (cfg_fire) begin
      unique case (cfg_index_i)
        RegWidth:  width_q  <= cfg_data_i;
        RegHeight: height_q <= cfg_data_i;
        RegRadius: radius_q <= cfg_data_i[2:0];
        RegThresh: thresh_q <= cfg_data_i[6:0];
        default:   ;
      endcase
      in_col_q  <= '0;
      in_row_q  <= '0;
      lin_q     <= '0;
      ic_q      <= '0;
      ir_q      <= '0;
      oc_q      <= '0;
      or_q      <= '0;
      inf_act_q <= 1'b0;
      out_act_q <= 1'b0;
    end else if (in_fire) begin
      if (is_last) begin
        in_col_q  <= '0;
        in_row_q  <= '0;
        lin_q     <= '0;
        ic_q      <= '0;
        ir_q      <= '0;
        oc_q      <= '0;
        or_q      <= '0;
        inf_act_q <= 1'b0;
        out_act_q <= 1'b0;
      end else begin
        lin_q <= lin_q + 1'b1;
        if ({1'b0, in_col_q} + 1'b1 >= w_eff) begin
          in_col_q <= '0;
          in_row_q <= in_row_q + 1'b1;
        end else begin
          in_col_q <= in_col_q + 1'b1;
        end
        if (inf_go) begin
          inf_act_q <= 1'b1;
          if ({1'b0, ic_q} + 1'b1 >= w_eff) begin
            ic_q <= '0;
            ir_q <= ir_q + 1'b1;
          end else begin
            ic_q <= ic_q + 1'b1;
          end
        end
        if (out_go) begin
          out_act_q <= 1'b1;
          if ({1'b0, oc_q} + 1'b1 >= w_eff) begin
            oc_q <= '0;
            or_q <= or_q + 1'b1;
          end else begin
            oc_q <= oc_q + 1'b1;
          end
        end
      end
    end
  end

  // raw class ring: written on accept, read during the window scan
  always_ff @(posedge clk_i) begin
    if (in_fire && in_grid) begin
      raw_mem[{in_row_q[RawRowsLog-1:0], in_col_q}] <=
        cmd_i ? ClsUnk : classify(cell_value_i, thresh_q);
    end
    raw_rd_q <= raw_mem[{sy_q[RawRowsLog-1:0], sx_q}];
  end

  // inflated class ring: written after the raw scan, read for the frontier test
  always_ff @(posedge clk_i) begin
    if (state_q == StInfWr) begin
      inf_mem[{b_q[InfRowsLog-1:0], a_q}] <= occ_q ? ClsOcc : ctrcls_q;
    end
    inf_rd_q <= inf_mem[{sy_q[InfRowsLog-1:0], sx_q}];
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      rv_q        <= 1'b0;
      iv_q        <= 1'b0;
      ctr_q       <= 1'b0;
      a_q         <= '0;
      b_q         <= '0;
      x_q         <= '0;
      y_q         <= '0;
      sx_q        <= '0;
      sy_q        <= '0;
      last_q      <= 1'b0;
      out_go_q    <= 1'b0;
      occ_q       <= 1'b0;
      unk_q       <= 1'b0;
      ctrcls_q    <= ClsFree;
      fcls_q      <= ClsFree;
      ox_q        <= '0;
      oy_q        <= '0;
      ocls_q      <= ClsFree;
      front_q     <= 1'b0;
      olast_q     <= 1'b0;
    end else begin
      rv_q  <= (state_q == StScan);
      iv_q  <= (state_q == StFScan);
      ctr_q <= scanning && at_ctr;
      // a result taken while a new one is loaded is replaced in StEmit
      if (out_valid_q && out_ready_i && (state_q != StEmit)) out_valid_q <= 1'b0;

      unique case (state_q) inside
        StIdle: begin
          if (in_fire) begin
            a_q      <= ic_q;
            b_q      <= ir_q[RowW-1:0];
            x_q      <= oc_q;
            y_q      <= or_q;
            last_q   <= is_last;
            out_go_q <= out_go;
            occ_q    <= 1'b0;
            unk_q    <= 1'b0;
            if (inf_do) begin
              sx_q    <= lo_b(ic_q, radius_q);
              sy_q    <= lo_b(ir_q[RowW-1:0], radius_q);
              state_q <= StScan;
            end else if (out_go) begin
              sx_q    <= lo_b(oc_q, RadW'(1));
              sy_q    <= lo_b(or_q, RadW'(1));
              state_q <= StFScan;
            end
          end
        end
        StScan, StFScan: begin
          if (sx_q == xhi) begin
            sx_q <= xlo;
            if (sy_q == yhi) begin
              state_q <= (state_q == StScan) ? StDrain : StFDrain;
            end else begin
              sy_q <= sy_q + 1'b1;
            end
          end else begin
            sx_q <= sx_q + 1'b1;
          end
        end
        StDrain: state_q <= StInfWr;
        StInfWr: begin
          if (out_go_q) begin
            sx_q    <= lo_b(x_q, RadW'(1));
            sy_q    <= lo_b(y_q, RadW'(1));
            state_q <= StFScan;
          end else begin
            state_q <= StIdle;
          end
        end
        StFDrain: state_q <= StEmit;
        StEmit: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            ox_q        <= x_q;
            oy_q        <= y_q;
            ocls_q      <= fcls_q;
            front_q     <= (fcls_q == ClsFree) && unk_q;
            olast_q     <= last_q;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase

      // collect read data in the cycle after each address
      if (rv_q) begin
        if (raw_rd_q == ClsOcc) occ_q <= 1'b1;
        if (ctr_q) ctrcls_q <= raw_rd_q;
      end
      if (iv_q) begin
        if (ctr_q) fcls_q <= inf_rd_q;
        else if (inf_rd_q == ClsUnk) unk_q <= 1'b1;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign cell_x_o         = ox_q;
  assign cell_y_o         = oy_q;
  assign inflated_class_o = ocls_q;
  assign is_frontier_o    = front_q;
  assign last_o           = olast_q;

endmodule

// ===== dv/occupancy_inflate_frontier_unit_tb.sv =====
module occupancy_inflate_frontier_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import oif_pkg::*;

  localparam bit CmdCell  = 1'b0;
  localparam bit CmdFlush = 1'b1;
  localparam int RingRows = 3 * MaxRadius + 4;
  localparam int SettleCycles = 400;

  typedef struct packed {
    logic       cmd;
    logic [7:0] value;
  } cell_item_t;

  typedef struct packed {
    logic [ColW-1:0] x;
    logic [RowW-1:0] y;
    logic [1:0]      cls;
    logic            front;
    logic            last;
  } cell_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready_o;
  logic cmd_drv = 1'b0;
  logic signed [7:0] value_drv = '0;
  logic out_valid_o;
  logic out_ready = 1'b0;
  logic [ColW-1:0] cell_x_o;
  logic [RowW-1:0] cell_y_o;
  logic [1:0] inflated_class_o;
  logic is_frontier_o;
  logic last_o;
  logic cfg_valid = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index = '0;
  logic [10:0] cfg_data = '0;

  occupancy_inflate_frontier_unit i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_ready_o(in_ready_o),
    .cmd_i(cmd_drv), .cell_value_i(value_drv),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready),
    .cell_x_o(cell_x_o), .cell_y_o(cell_y_o),
    .inflated_class_o(inflated_class_o), .is_frontier_o(is_frontier_o), .last_o(last_o),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  always #2 clk_i = ~clk_i;

  // stimulus and expectation stores
  cell_item_t   pending_cells[$];
  cell_result_t expected_cells[$];
  int  errors = 0;
  int  results_seen = 0;
  int  items_sent = 0;
  int  grids_sent = 0;
  bit  calm = 1'b0;
  bit  hold_go = 1'b0;
  int  hold_left = 500;
  logic in_fire = 1'b0;

  // grid model state
  logic [1:0]  raw_ring[RingRows][MaxWidth];
  logic [10:0] width_reg, height_reg;
  logic [2:0]  radius_reg;
  logic [6:0]  thresh_reg;
  int in_col, in_row, out_col, out_row;
  bit out_active;

  function automatic int eff_width();
    if (width_reg == 0) return 1;
    return (width_reg > MaxWidth) ? MaxWidth : int'(width_reg);
  endfunction

  function automatic int eff_height();
    if (height_reg == 0) return 1;
    return (height_reg > MaxHeight) ? MaxHeight : int'(height_reg);
  endfunction

  function automatic logic [1:0] raw_class(input logic signed [7:0] v);
    if (v >= 0 && int'(v) < int'(thresh_reg)) return ClsFree;
    if (v == -8'sd1) return ClsUnk;
    return ClsOcc;
  endfunction

  // occupied if any occupied raw cell within the Chebyshev window, else the centre's raw class
  function automatic logic [1:0] inflated_at(input int x, input int y, input int w,
                                             input int h, input int r);
    for (int yy = y - r; yy <= y + r; yy++) begin
      if (yy < 0 || yy >= h) continue;
      for (int xx = x - r; xx <= x + r; xx++) begin
        if (xx < 0 || xx >= w) continue;
        if (raw_ring[yy % RingRows][xx] == ClsOcc) return ClsOcc;
      end
    end
    return raw_ring[y % RingRows][x];
  endfunction

  task automatic restart_stream();
    in_col = 0; in_row = 0; out_col = 0; out_row = 0; out_active = 0;
  endtask

  task automatic apply_register(input logic [1:0] idx, input logic [10:0] data);
    case (idx)
      RegWidth:  width_reg  = data;
      RegHeight: height_reg = data;
      RegRadius: radius_reg = data[2:0];
      RegThresh: thresh_reg = data[6:0];
      default: ;
    endcase
    restart_stream();
  endtask

  // one accepted transaction: store the raw class, emit the delayed cell result
  task automatic predict_cell(input logic cmd, input logic signed [7:0] v);
    int w, h, r, delay;
    cell_result_t res;
    w = eff_width(); h = eff_height(); r = radius_reg;
    delay = (r + 1) * w + r + 1;
    if (in_row < h && in_col < w)
      raw_ring[in_row % RingRows][in_col] = cmd ? ClsUnk : raw_class(v);
    if (!out_active && in_row * w + in_col == delay) begin
      out_active = 1; out_col = 0; out_row = 0;
    end
    if (out_active) begin
      res.x = out_col[ColW-1:0];
      res.y = out_row[RowW-1:0];
      res.cls = inflated_at(out_col, out_row, w, h, r);
      res.front = 1'b0;
      res.last = (out_col == w - 1 && out_row == h - 1);
      if (res.cls == ClsFree) begin
        for (int dy = -1; dy <= 1; dy++) begin
          for (int dx = -1; dx <= 1; dx++) begin
            if (dx == 0 && dy == 0) continue;
            if (out_col + dx < 0 || out_col + dx >= w) continue;
            if (out_row + dy < 0 || out_row + dy >= h) continue;
            if (inflated_at(out_col + dx, out_row + dy, w, h, r) == ClsUnk) res.front = 1'b1;
          end
        end
      end
      expected_cells = {expected_cells, res};
      if (res.last) begin
        restart_stream();
        return;
      end
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
  endtask

  // monitor: model update on accepted transactions, result check
  always @(posedge clk_i) begin
    cell_result_t exp_res;
    in_fire <= in_valid && in_ready_o;
    if (rst_ni) begin
      if (cfg_valid && cfg_ready_o) apply_register(cfg_index, cfg_data);
      if (in_valid && in_ready_o) predict_cell(cmd_drv, value_drv);
      if (out_valid_o && out_ready) begin
        results_seen++;
        if (expected_cells.size() == 0) begin
          $error("unexpected result x=%0d y=%0d", cell_x_o, cell_y_o);
          errors++;
        end else begin
          exp_res = expected_cells.pop_front();
          if (cell_x_o !== exp_res.x) begin
            $error("cell_x expected %0d got %0d", exp_res.x, cell_x_o); errors++;
          end
          if (cell_y_o !== exp_res.y) begin
            $error("cell_y expected %0d got %0d", exp_res.y, cell_y_o); errors++;
          end
          if (inflated_class_o !== exp_res.cls) begin
            $error("inflated_class expected %0d got %0d", exp_res.cls, inflated_class_o);
            errors++;
          end
          if (is_frontier_o !== exp_res.front) begin
            $error("is_frontier expected %0d got %0d", exp_res.front, is_frontier_o);
            errors++;
          end
          if (last_o !== exp_res.last) begin
            $error("last expected %0d got %0d", exp_res.last, last_o); errors++;
          end
        end
      end
    end
  end

  // driver: next item once the current one is taken
  always @(negedge clk_i) begin
    cell_item_t it;
    if (rst_ni && (!in_valid || in_fire)) begin
      if (pending_cells.size() != 0 && (calm || $urandom_range(99) >= 36)) begin
        it = pending_cells.pop_front();
        cmd_drv <= it.cmd;
        value_drv <= it.value;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off
  always @(negedge clk_i) begin
    if (hold_go && hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 36);
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [10:0] data);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_grid(input int w, input int h, input int r, input int thr);
    write_reg(RegWidth, w[10:0]);
    write_reg(RegHeight, h[10:0]);
    write_reg(RegRadius, r[10:0]);
    write_reg(RegThresh, thr[10:0]);
  endtask

  task automatic push_item(input logic cmd, input logic [7:0] v);
    cell_item_t it;
    it.cmd = cmd;
    it.value = v;
    pending_cells = {pending_cells, it};
    items_sent++;
  endtask

  // random cell value biased toward unknown and free
  function automatic logic [7:0] pick_value();
    int k;
    k = $urandom_range(99);
    if (k < 25) return 8'hFF;
    if (k < 55) return 8'($urandom_range(thresh_reg > 0 ? thresh_reg - 1 : 0));
    return 8'($urandom);
  endfunction

  // one whole grid with random content and its padding
  task automatic push_grid();
    int w, h, r;
    w = eff_width(); h = eff_height(); r = radius_reg;
    for (int i = 0; i < w * h; i++) begin
      if ($urandom_range(99) < 5) push_item(CmdFlush, 8'($urandom));
      else push_item(CmdCell, pick_value());
    end
    for (int i = 0; i < (r + 1) * w + r + 1; i++) begin
      if ($urandom_range(99) < 20) push_item(CmdCell, 8'($urandom));
      else push_item(CmdFlush, 8'($urandom));
    end
    grids_sent++;
  endtask

  task automatic settle();
    while (pending_cells.size() != 0 || in_valid || expected_cells.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    logic [7:0] directed_vals[20];
    width_reg = ResetWidth; height_reg = ResetHeight;
    radius_reg = ResetRadius; thresh_reg = ResetThresh;
    restart_stream();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes, threshold edges, in-grid flush, padding with data
    set_grid(5, 4, 1, 65);
    directed_vals = '{8'h80, 8'h7F, 8'hFF, 8'h00, 8'd64, 8'd65, 8'hFE, 8'd1, 8'hFF, 8'hFF,
                      8'h00, 8'h00, 8'hFF, 8'd10, 8'd20, 8'd0, 8'd30, 8'hFF, 8'd5, 8'd0};
    foreach (directed_vals[i])
      push_item((i == 9) ? CmdFlush : CmdCell, directed_vals[i]);
    for (int i = 0; i < 2 * 5 + 2; i++) push_item(i % 3 == 0 ? CmdCell : CmdFlush, 8'h55);
    settle();

    // register extremes: zero and oversize sizes, widest radius, threshold ends
    set_grid(0, 3, 0, 0);      push_grid(); settle();
    set_grid(1, 2047, 0, 1);
    for (int i = 0; i < 60; i++) push_item(CmdCell, pick_value());
    settle();
    set_grid(4, 0, 7, 127);    push_grid(); settle();
    set_grid(9, 8, 7, 50);     push_grid(); settle();

    // restart: partial grid dropped by a register write
    set_grid(6, 6, 2, 40);
    for (int i = 0; i < 10; i++) push_item(CmdCell, pick_value());
    settle();

    // random grids; one phase without stalls, one with a long hold-off
    for (int ph = 0; ph < 2 || items_sent < 700; ph++) begin
      set_grid($urandom_range(1, 10), $urandom_range(1, 8),
               ($urandom_range(9) == 0) ? 7 : $urandom_range(0, 3), $urandom_range(0, 127));
      calm = (ph == 0);
      if (ph == 1) hold_go = 1'b1;
      repeat ($urandom_range(1, 3)) push_grid();
      settle();
    end
    calm = 1'b0;

    $display("tb: %0d items in %0d grids, %0d cell results checked", items_sent, grids_sent,
             results_seen);
    $display("tb: covered size clamps, threshold ends, radius 0..7, restarts and a long stall");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule
